@@ hdl/zph_pkg.sv @@
// Shared types, constants and helper functions for the Zobrist position hash block.
// No dependencies; every other file in hdl/ imports this package.
package zph_pkg;

    localparam int SQUARES     = 64;
    localparam int SQ_W        = $clog2(SQUARES);
    localparam int PIECE_KINDS = 12;
    localparam int PIECE_W     = 4;
    localparam int CASTLE_KEYS = 4;
    localparam int EP_KEYS     = 8;

    localparam int CASTLE_BASE = PIECE_KINDS * SQUARES;
    localparam int EP_BASE     = CASTLE_BASE + CASTLE_KEYS;
    localparam int TURN_INDEX  = EP_BASE + EP_KEYS;
    localparam int PAWN_BASE   = TURN_INDEX + 1;
    localparam int KEY_COUNT   = PAWN_BASE + SQUARES;
    localparam int KEY_AW      = $clog2(KEY_COUNT);

    // Keys above the piece table, addressed as bits of one select mask.
    localparam int TAIL_W  = PAWN_BASE - CASTLE_BASE;
    localparam int XMASK_W = KEY_COUNT - CASTLE_BASE;
    localparam int XIDX_W  = $clog2(XMASK_W);

    localparam logic [63:0] GEN_SEED = 64'd314159265;
    localparam logic [63:0] GEN_MULT = 64'd2685821657736338717;
    localparam int GEN_SH_A = 12;
    localparam int GEN_SH_B = 25;
    localparam int GEN_SH_C = 27;

    localparam logic FUNC_BOARD = 1'b0;
    localparam logic FUNC_PAWN  = 1'b1;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_PAWN     = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [SQ_W-1:0]        square;
        logic [PIECE_W-1:0]     piece;
        logic                   last;
        logic [CASTLE_KEYS-1:0] castle_bits;
        logic signed [3:0]      ep_col;
        logic                   black_to_move;
        logic [SQUARES-1:0]     pawn_mask;
    } req_t;

    typedef struct packed {
        logic [63:0] hash;
        logic        hash_kind;
    } rsp_t;

    // One classified work item passed from front to back.
    typedef struct packed {
        logic               kind;
        logic               emit;
        logic               piece_hit;
        logic [KEY_AW-1:0]  piece_addr;
        logic [XMASK_W-1:0] xmask;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [63:0]       data;
    } key_wr_t;

    typedef enum logic [2:0] {
        FILL_SHIFT,
        FILL_MUL0,
        FILL_MUL1,
        FILL_MUL2,
        FILL_ADD,
        FILL_WRITE,
        FILL_DONE
    } fill_state_t;

    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> GEN_SH_A);
        t = t ^ (t << GEN_SH_B);
        t = t ^ (t >> GEN_SH_C);
        return t;
    endfunction

endpackage

@@ hdl/zph_fill.sv @@
// Key fill sequencer: xorshift64* generator, one shared 32x32 multiplier.
// Depends on zph_pkg; writes keys into the key memory held by zph_back.
module zph_fill
    import zph_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output key_wr_t key_wr,
    output logic    fill_done
);

    fill_state_t       state_reg, state_next;
    logic [63:0]       gen_reg, gen_next;
    logic [KEY_AW-1:0] idx_reg, idx_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       key_reg, key_next;
    logic [31:0]       mul_a, mul_b;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FILL_SHIFT: state_next = FILL_MUL0;
            FILL_MUL0:  state_next = FILL_MUL1;
            FILL_MUL1:  state_next = FILL_MUL2;
            FILL_MUL2:  state_next = FILL_ADD;
            FILL_ADD:   state_next = FILL_WRITE;
            FILL_WRITE:
            begin
                if (idx_reg == KEY_AW'(KEY_COUNT - 1))
                    state_next = FILL_DONE;
                else
                    state_next = FILL_SHIFT;
            end
            FILL_DONE:  state_next = FILL_DONE;
            default:    state_next = FILL_DONE;
        endcase
    end

    // Outputs and multiplier operand select
    always_comb
    begin
        key_wr    = '0;
        fill_done = 1'b0;
        mul_a     = gen_reg[31:0];
        mul_b     = GEN_MULT[31:0];
        case (state_reg)
            FILL_MUL1:
            begin
                mul_a = gen_reg[31:0];
                mul_b = GEN_MULT[63:32];
            end
            FILL_MUL2:
            begin
                mul_a = gen_reg[63:32];
                mul_b = GEN_MULT[31:0];
            end
            FILL_WRITE:
            begin
                key_wr.en   = 1'b1;
                key_wr.addr = idx_reg;
                key_wr.data = key_reg;
            end
            FILL_DONE: fill_done = 1'b1;
            default: ;
        endcase
    end

    // Datapath: low product, then the two cross products into the upper half
    always_comb
    begin
        gen_next  = gen_reg;
        idx_next  = idx_reg;
        key_next  = key_reg;
        prod_next = mul_a * mul_b;
        case (state_reg)
            FILL_SHIFT: gen_next = xorshift_step(gen_reg);
            FILL_MUL1:  key_next = prod_reg;
            FILL_MUL2:  key_next[63:32] = key_reg[63:32] + prod_reg[31:0];
            FILL_ADD:   key_next[63:32] = key_reg[63:32] + prod_reg[31:0];
            FILL_WRITE: idx_next = idx_reg + KEY_AW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_SHIFT;
            gen_reg   <= GEN_SEED;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        key_reg  <= key_next;
    end

endmodule

@@ hdl/zph_front.sv @@
// Front end: accepts request transactions, turns each into a job, queues it.
// Depends on zph_pkg; feeds zph_back through a two-entry job queue.
module zph_front
    import zph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fill_done,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic job_valid,
    output job_t job,
    input  logic job_pop
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    job_t              q_mem_reg [QDEPTH];
    logic [QPW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]      cnt_reg, cnt_next;
    job_t              new_job;
    logic [EP_KEYS-1:0] ep_hot;
    logic              push;

    assign req_stall = !fill_done || (cnt_reg == (QPW+1)'(QDEPTH));
    assign push      = req_valid && !req_stall;

    // Classify: piece key address plus a select mask over the upper keys
    always_comb
    begin
        ep_hot  = req.ep_col[3] ? '0 : (EP_KEYS'(1) << req.ep_col[2:0]);
        new_job = '0;
        if (req.func == FUNC_PAWN)
        begin
            new_job.kind  = KIND_POSITION ^ KIND_PAWN ^ KIND_POSITION;
            new_job.emit  = 1'b1;
            new_job.xmask = {req.pawn_mask, TAIL_W'(0)};
        end
        else
        begin
            new_job.kind       = KIND_POSITION;
            new_job.emit       = req.last;
            new_job.piece_hit  = req.piece inside {[PIECE_W'(1):PIECE_W'(PIECE_KINDS)]};
            new_job.piece_addr = KEY_AW'(KEY_AW'(req.piece - PIECE_W'(1)) * KEY_AW'(SQUARES)
                                 + KEY_AW'(req.square));
            if (req.last)
                new_job.xmask = XMASK_W'({req.black_to_move, ep_hot, req.castle_bits});
        end
    end

    assign job_valid = (cnt_reg != '0);
    assign job       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !job_pop)
            cnt_next = cnt_reg + (QPW+1)'(1);
        else if (!push && job_pop)
            cnt_next = cnt_reg - (QPW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            if (job_pop)
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= new_job;
    end

endmodule

@@ hdl/zph_back.sv @@
// Back end: key memory, one-read-per-cycle XOR engine, result register.
// Depends on zph_pkg; takes jobs from zph_front and keys from zph_fill.
module zph_back
    import zph_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  key_wr_t key_wr,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output rsp_t    rsp
);

    logic [63:0]       key_mem [KEY_COUNT];
    logic [63:0]       rd_data_reg;
    logic              rd_pend_reg, rd_tag_reg;
    logic              issue, issue_tag;
    logic [KEY_AW-1:0] rd_addr;

    logic              cur_valid_reg, cur_valid_next;
    job_t              cur_reg, cur_next;
    logic              fin_valid_reg, fin_valid_next;
    logic              fin_kind_reg, fin_kind_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       pawn_reg, pawn_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              out_free, fin_fire, eng_run, done, load;
    logic [XMASK_W-1:0] rem_mask;
    logic              rem_piece;
    logic [XIDX_W-1:0] low_idx;
    logic [63:0]       land_acc, land_pawn, fin_value;

    function automatic logic [XIDX_W-1:0] lowest_set(input logic [XMASK_W-1:0] m);
        logic [XIDX_W-1:0] r;
        r = '0;
        for (int i = XMASK_W - 1; i >= 0; i--)
            if (m[i])
                r = XIDX_W'(i);
        return r;
    endfunction

    assign out_free = !out_valid_reg || !rsp_stall;
    assign fin_fire = fin_valid_reg && out_free;
    assign eng_run  = !fin_valid_reg || out_free;

    assign land_acc  = (rd_pend_reg && rd_tag_reg == KIND_POSITION) ? rd_data_reg : '0;
    assign land_pawn = (rd_pend_reg && rd_tag_reg == KIND_PAWN) ? rd_data_reg : '0;
    assign fin_value = (fin_kind_reg == KIND_PAWN) ? (pawn_reg ^ land_pawn)
                                                   : (acc_reg ^ land_acc);

    // Issue at most one key read per cycle for the current job
    always_comb
    begin
        low_idx   = lowest_set(cur_reg.xmask);
        issue     = 1'b0;
        issue_tag = cur_reg.kind;
        rd_addr   = cur_reg.piece_addr;
        rem_piece = cur_reg.piece_hit;
        rem_mask  = cur_reg.xmask;
        if (cur_valid_reg && eng_run)
        begin
            if (cur_reg.piece_hit)
            begin
                issue     = 1'b1;
                rem_piece = 1'b0;
            end
            else if (cur_reg.xmask != '0)
            begin
                issue    = 1'b1;
                rd_addr  = KEY_AW'(CASTLE_BASE) + KEY_AW'(low_idx);
                rem_mask = cur_reg.xmask & (cur_reg.xmask - XMASK_W'(1));
            end
        end
        done = cur_valid_reg && eng_run && !rem_piece && (rem_mask == '0);
        load = eng_run && (!cur_valid_reg || done) && job_valid;
    end

    assign job_pop = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (cur_valid_reg && eng_run && !done)
        begin
            cur_next.piece_hit = rem_piece;
            cur_next.xmask     = rem_mask;
        end
        else if (load)
        begin
            cur_valid_next = 1'b1;
            cur_next       = job;
        end
        else if (done)
            cur_valid_next = 1'b0;

        fin_valid_next = fin_valid_reg && !fin_fire;
        fin_kind_next  = fin_kind_reg;
        if (done && cur_reg.emit)
        begin
            fin_valid_next = 1'b1;
            fin_kind_next  = cur_reg.kind;
        end

        acc_next  = acc_reg ^ land_acc;
        pawn_next = pawn_reg ^ land_pawn;
        if (fin_fire && fin_kind_reg == KIND_POSITION)
            acc_next = '0;
        if (fin_fire && fin_kind_reg == KIND_PAWN)
            pawn_next = '0;

        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        if (fin_fire)
        begin
            out_valid_next    = 1'b1;
            out_next.hash      = fin_value;
            out_next.hash_kind = fin_kind_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk)
    begin
        if (key_wr.en)
            key_mem[key_wr.addr] <= key_wr.data;
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            rd_tag_reg    <= KIND_POSITION;
            cur_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
            fin_kind_reg  <= KIND_POSITION;
            acc_reg       <= '0;
            pawn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= issue;
            rd_tag_reg    <= issue_tag;
            cur_valid_reg <= cur_valid_next;
            fin_valid_reg <= fin_valid_next;
            fin_kind_reg  <= fin_kind_next;
            acc_reg       <= acc_next;
            pawn_reg      <= pawn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

@@ hdl/zobrist_position_hash.sv @@
// Zobrist position hash, top level: fill sequencer, front end and back end.
// Depends on zph_pkg, zph_fill, zph_front and zph_back.
//
// After reset the block fills its 845-entry key memory from an xorshift64*
// generator (seed 314159265). For each key the 64-bit multiply runs as three
// 32x32 partial products on one multiplier; req_stall stays high until the
// fill is done. Afterwards a board transaction with piece code 1 to 12 adds
// the key of its piece on its square to the position accumulator; the last
// board transaction of a position also adds the set castle-right keys, the
// en-passant column key (unless ep_col is negative) and, with black to move,
// the turn key, returns the position hash (hash_kind 0) and clears the
// accumulator. A pawn transaction returns the XOR of the pawn keys at the set
// bits of its mask (hash_kind 1) and leaves the accumulator alone. The key
// memory has one read port, so the back end issues one key read per cycle
// unless a finished result is held up by rsp_stall: a board item reads its
// piece key if any, a last item also its set castle, en-passant and turn keys,
// a pawn item the keys at its set mask bits. After the last read the result
// passes through fin_valid_reg into out_reg. A two-entry job queue lets the
// front keep accepting while the back end works or a result waits on rsp_stall.
module zobrist_position_hash
    import zph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    key_wr_t key_wr;
    logic    fill_done;
    logic    job_valid;
    job_t    job;
    logic    job_pop;

    zph_fill u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_wr    (key_wr),
        .fill_done (fill_done)
    );

    zph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fill_done (fill_done),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    zph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_wr    (key_wr),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
